// ----- rtl/core/scasc_pkg.sv -----
package scasc_pkg;

	// scancodes with a special meaning
	localparam logic [7:0] SC_CAPS_LOCK     = 8'h3A;
	localparam logic [7:0] SC_LSHIFT_MAKE   = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE   = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK  = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK  = 8'hB6;

	// distance between upper and lower case letters
	localparam logic [6:0] CASE_OFFSET      = 7'd32;

	localparam logic [6:0] CH_LOWER_A       = 7'h61;
	localparam logic [6:0] CH_LOWER_Z       = 7'h7A;
	localparam logic [6:0] CH_UPPER_A       = 7'h41;
	localparam logic [6:0] CH_UPPER_Z       = 7'h5A;

	typedef logic [6:0] ascii_t;
	typedef logic [7:0] scan_t;

	// us layout, no modifier
	function automatic ascii_t plain_rom(input logic [6:0] idx);
		ascii_t ch;
		unique case (idx)
			7'h01: ch = 7'h1B;
			7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33; 7'h05: ch = 7'h34;
			7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37; 7'h09: ch = 7'h38;
			7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D; 7'h0D: ch = 7'h3D;
			7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
			7'h10: ch = 7'h71; 7'h11: ch = 7'h77; 7'h12: ch = 7'h65; 7'h13: ch = 7'h72;
			7'h14: ch = 7'h74; 7'h15: ch = 7'h79; 7'h16: ch = 7'h75; 7'h17: ch = 7'h69;
			7'h18: ch = 7'h6F; 7'h19: ch = 7'h70; 7'h1A: ch = 7'h5B; 7'h1B: ch = 7'h5D;
			7'h1C: ch = 7'h0A; 7'h1E: ch = 7'h61; 7'h1F: ch = 7'h73;
			7'h20: ch = 7'h64; 7'h21: ch = 7'h66; 7'h22: ch = 7'h67; 7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A; 7'h25: ch = 7'h6B; 7'h26: ch = 7'h6C; 7'h27: ch = 7'h3B;
			7'h28: ch = 7'h27; 7'h29: ch = 7'h60; 7'h2B: ch = 7'h5C;
			7'h2C: ch = 7'h7A; 7'h2D: ch = 7'h78; 7'h2E: ch = 7'h63; 7'h2F: ch = 7'h76;
			7'h30: ch = 7'h62; 7'h31: ch = 7'h6E; 7'h32: ch = 7'h6D; 7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
			7'h4A: ch = 7'h2D; 7'h4E: ch = 7'h2B;
			default: ch = '0;
		endcase
		return ch;
	endfunction

	// us layout, shift held
	function automatic ascii_t shift_rom(input logic [6:0] idx);
		ascii_t ch;
		unique case (idx)
			7'h01: ch = 7'h1B;
			7'h02: ch = 7'h21; 7'h03: ch = 7'h40; 7'h04: ch = 7'h23; 7'h05: ch = 7'h24;
			7'h06: ch = 7'h25; 7'h07: ch = 7'h5E; 7'h08: ch = 7'h26; 7'h09: ch = 7'h2A;
			7'h0A: ch = 7'h28; 7'h0B: ch = 7'h29; 7'h0C: ch = 7'h5F; 7'h0D: ch = 7'h2B;
			7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
			7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
			7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
			7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h7B; 7'h1B: ch = 7'h7D;
			7'h1C: ch = 7'h0A; 7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53;
			7'h20: ch = 7'h44; 7'h21: ch = 7'h46; 7'h22: ch = 7'h47; 7'h23: ch = 7'h48;
			7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B; 7'h26: ch = 7'h4C; 7'h27: ch = 7'h3A;
			7'h28: ch = 7'h22; 7'h29: ch = 7'h7E; 7'h2B: ch = 7'h7C;
			7'h2C: ch = 7'h5A; 7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43; 7'h2F: ch = 7'h56;
			7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D; 7'h33: ch = 7'h3C;
			7'h34: ch = 7'h3E; 7'h35: ch = 7'h3F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
			7'h4A: ch = 7'h2D; 7'h4E: ch = 7'h2B;
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/core/scancode_to_ascii_with_modifiers_unit.sv -----
// set-1 scancode to us ascii translator with shift and caps-lock tracking
//
// s_axis: one scancode byte per beat in tdata; bit 7 set marks a key release
// m_axis: one ascii character per beat in tdata[6:0], tdata[7] always zero
// codes that only change modifier state (caps lock, shift make and break),
// release codes and keys with no character give no output beat
//
// path: a character reaches m_axis by way of the input register and then
// the output register
// throughput: one scancode per cycle, limited only by the output register;
// the input register refills in the same cycle it hands its byte on
//
// when m_axis stalls the output register holds its beat, the input register
// keeps the next byte and s_axis_tready drops until the output frees up
//
// reset clears both pipeline valids and sets shift and caps lock to released
module scancode_to_ascii_with_modifiers_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  scasc_pkg::scan_t       s_axis_tdata,   // [7:0] scan_code
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [7:0]             m_axis_tdata    // [6:0] ascii_char, [7] zero
);

	import scasc_pkg::*;

	// input register
	logic   valid_s1;
	scan_t  code_s1;

	// output register
	logic   valid_s2;
	ascii_t char_s2;

	// modifier state
	logic   shift_q;
	logic   caps_q;

	logic   advance;
	logic   is_caps;
	logic   is_shift_make;
	logic   is_shift_break;
	logic   emit;
	ascii_t rom_char;
	ascii_t out_char;

	// the input register moves on whenever the output register is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign is_caps        = (code_s1 == SC_CAPS_LOCK);
	assign is_shift_make  = (code_s1 == SC_LSHIFT_MAKE) || (code_s1 == SC_RSHIFT_MAKE);
	assign is_shift_break = (code_s1 == SC_LSHIFT_BREAK) || (code_s1 == SC_RSHIFT_BREAK);

	always_comb begin
		rom_char = shift_q ? shift_rom(code_s1[6:0]) : plain_rom(code_s1[6:0]);
		out_char = rom_char;
		// caps lock flips letter case, back to lower when shift is also held
		if (caps_q && !shift_q && rom_char >= CH_LOWER_A && rom_char <= CH_LOWER_Z) begin
			out_char = rom_char - CASE_OFFSET;
		end else if (caps_q && shift_q && rom_char >= CH_UPPER_A
			&& rom_char <= CH_UPPER_Z) begin
			out_char = rom_char + CASE_OFFSET;
		end
		// modifier codes have no rom entry, release codes are filtered by bit 7
		emit = !code_s1[7] && (out_char != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			code_s1 <= s_axis_tdata;
		end
	end

	// modifier flags change as the byte leaves the input register, in stream order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (advance) begin
			if (is_caps) begin
				caps_q <= !caps_q;
			end
			if (is_shift_make) begin
				shift_q <= 1'b1;
			end else if (is_shift_break) begin
				shift_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			char_s2 <= out_char;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, char_s2};

endmodule
